// ===== hdl/msr_pkg.sv =====
// Shared types and constants for the motor setpoint slew ramp.
package msr_pkg;

    localparam int VAL_W      = 11;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 2;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [STEP_W-1:0] t_step;

    // Button flags of one request, applied in field order.
    typedef struct packed {
        logic up;
        logic mirror;
        logic down;
    } t_btn;

    localparam t_val BUTTON_STEP = t_val'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 2'd1;

    localparam t_val  FULL_SCALE_RST = t_val'(512);
    localparam t_step RAMP_STEP_RST  = t_step'(8);
    localparam t_val  TARGET_RST     = t_val'(256);
    localparam t_val  POSITION_RST   = t_val'(256);

endpackage

// ===== hdl/motor_setpoint_slew_ramp_unit.sv =====
// Top level of the motor setpoint slew ramp: request and result stages, state, config.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+---------------------------------------------
//  cfg     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//  in      | i_in_valid / o_in_ready    | i_press_up, i_press_mirror, i_press_down,
//          |                            | i_ramp_tick
//  out     | o_out_valid / i_out_ready  | o_motor_speed, o_forward_led, o_reverse_led,
//          |                            | o_target_now, o_position_now
//
//  One request per cycle while results drain; a taken request is held in the
//  request register, then moved to the output register. The target and position
//  registers close a loop through the button and ramp logic, which sets that rate.
//  Synchronous active-low reset restores full_scale, ramp_step, target and position.
//  A stalled result holds in the output register; the request stage keeps accepting
//  while that register is free or being drained.
module motor_setpoint_slew_ramp_unit import msr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [VAL_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_press_up,
    input  logic                    i_press_mirror,
    input  logic                    i_press_down,
    input  logic                    i_ramp_tick,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_motor_speed,
    output logic                    o_forward_led,
    output logic                    o_reverse_led,
    output logic [VAL_W-1:0]        o_target_now,
    output logic [VAL_W-1:0]        o_position_now
);

    t_val  r_full_scale;
    t_step r_ramp_step;
    t_val  r_target;
    t_val  r_position;

    logic  r_in_vld;
    t_btn  r_in_btn;
    logic  r_in_tick;

    logic                    r_out_vld;
    logic signed [VAL_W-1:0] r_speed;
    logic                    r_fwd;
    logic                    r_rev;
    t_val                    r_out_target;
    t_val                    r_out_position;

    logic                    adv;
    t_val                    n_target;
    t_val                    n_position;
    logic signed [VAL_W-1:0] n_speed;
    logic                    n_fwd;
    logic                    n_rev;

    // move the held request into the result register when it is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RST;
            r_ramp_step  <= RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                CFG_RAMP_STEP:  r_ramp_step  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_btn  <= '{up: i_press_up, mirror: i_press_mirror, down: i_press_down};
            r_in_tick <= i_ramp_tick;
        end
    end

    msr_target u_target (
        .i_full_scale (r_full_scale),
        .i_target     (r_target),
        .i_btn        (r_in_btn),
        .o_target     (n_target)
    );

    msr_ramp u_ramp (
        .i_full_scale (r_full_scale),
        .i_step       (r_ramp_step),
        .i_tick       (r_in_tick),
        .i_target     (n_target),
        .i_position   (r_position),
        .o_position   (n_position)
    );

    msr_speed u_speed (
        .i_full_scale (r_full_scale),
        .i_position   (n_position),
        .o_speed      (n_speed),
        .o_fwd        (n_fwd),
        .o_rev        (n_rev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_position <= POSITION_RST;
            r_out_vld  <= 1'b0;
        end else begin
            if (adv) begin
                r_target   <= n_target;
                r_position <= n_position;
                r_out_vld  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_speed        <= n_speed;
            r_fwd          <= n_fwd;
            r_rev          <= n_rev;
            r_out_target   <= n_target;
            r_out_position <= n_position;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_motor_speed  = r_speed;
    assign o_forward_led  = r_fwd;
    assign o_reverse_led  = r_rev;
    assign o_target_now   = r_out_target;
    assign o_position_now = r_out_position;

    a_state_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_target == r_target && r_out_position == r_position))
        else $error("result does not match the stored target and position");

    a_leds_follow_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_rev == r_speed[VAL_W-1] &&
                       r_fwd == (!r_speed[VAL_W-1] && r_speed != '0)))
        else $error("direction flags disagree with the speed");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while both stages are blocked");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_target) && $stable(r_position)))
        else $error("state changed without a request moving through");

endmodule

// ===== hdl/msr_target.sv =====
// Button handling: up, mirror and down applied to the target in order.
module msr_target import msr_pkg::*; (
    input  t_val i_full_scale,
    input  t_val i_target,
    input  t_btn i_btn,
    output t_val o_target
);

    logic [VAL_W:0] up_sum;
    t_val           t_up;
    t_val           fs_even;
    t_val           t_mir;
    t_val           t_dn;

    always_comb begin
        up_sum = {1'b0, i_target} + {1'b0, BUTTON_STEP};
        if (i_btn.up) begin
            t_up = (up_sum <= {1'b0, i_full_scale}) ? up_sum[VAL_W-1:0] : i_full_scale;
        end else begin
            t_up = i_target;
        end

        // reflect about the midpoint, saturate at zero
        fs_even = {i_full_scale[VAL_W-1:1], 1'b0};
        if (i_btn.mirror) begin
            t_mir = (t_up > fs_even) ? '0 : fs_even - t_up;
        end else begin
            t_mir = t_up;
        end

        if (i_btn.down) begin
            t_dn = (t_mir >= BUTTON_STEP) ? t_mir - BUTTON_STEP : '0;
        end else begin
            t_dn = t_mir;
        end
        o_target = t_dn;
    end

endmodule

// ===== hdl/msr_ramp.sv =====
// Ramp tick: snap at the ends or move the position one step toward the target.
module msr_ramp import msr_pkg::*; (
    input  t_val  i_full_scale,
    input  t_step i_step,
    input  logic  i_tick,
    input  t_val  i_target,
    input  t_val  i_position,
    output t_val  o_position
);

    t_val           step_ext;
    logic [VAL_W:0] t_plus_st;
    logic [VAL_W:0] p_plus_st;
    logic           near_low;
    logic           near_high;
    t_val           diff_tp;
    t_val           diff_pt;

    always_comb begin
        step_ext  = {{(VAL_W-STEP_W){1'b0}}, i_step};
        t_plus_st = {1'b0, i_target} + {1'b0, step_ext};
        p_plus_st = {1'b0, i_position} + {1'b0, step_ext};
        near_low  = (i_target < step_ext) && (i_position < step_ext);
        // x > fs - step, rewritten as x + step > fs to stay unsigned
        near_high = (t_plus_st > {1'b0, i_full_scale}) &&
                    (p_plus_st > {1'b0, i_full_scale});
        diff_tp   = i_target - i_position;
        diff_pt   = i_position - i_target;

        o_position = i_position;
        if (i_tick) begin
            if (near_low) begin
                o_position = '0;
            end else if (near_high) begin
                o_position = i_full_scale;
            end else if ((i_target > i_position) && (diff_tp >= step_ext)) begin
                o_position = i_position + step_ext;
            end else if ((i_target < i_position) && (diff_pt >= step_ext)) begin
                o_position = i_position - step_ext;
            end
        end
    end

endmodule

// ===== hdl/msr_speed.sv =====
// Drive value: midpoint minus position, saturated, with direction flags.
module msr_speed import msr_pkg::*; (
    input  t_val              i_full_scale,
    input  t_val              i_position,
    output logic signed [VAL_W-1:0] o_speed,
    output logic              o_fwd,
    output logic              o_rev
);

    logic signed [VAL_W:0] diff;

    always_comb begin
        diff = $signed({2'b00, i_full_scale[VAL_W-1:1]}) - $signed({1'b0, i_position});
        // midpoint never exceeds the positive limit, only clip below
        if (diff < -$signed((VAL_W+1)'(1 << (VAL_W-1)))) begin
            o_speed = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            o_speed = diff[VAL_W-1:0];
        end
        o_fwd = !o_speed[VAL_W-1] && (o_speed != '0);
        o_rev = o_speed[VAL_W-1];
    end

endmodule

// ===== test/motor_setpoint_slew_ramp_unit_tb.sv =====
// Testbench for the motor setpoint slew ramp: directed and random requests vs. a predictor.
`timescale 1ns / 1ps

module motor_setpoint_slew_ramp_unit_tb;
    import msr_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [VAL_W-1:0] speed;
        logic                    fwd;
        logic                    rev;
        t_val                    target;
        t_val                    position;
    } t_drive_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = CFG_FULL_SCALE;
    logic [VAL_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_press_up = 1'b0;
    logic                    i_press_mirror = 1'b0;
    logic                    i_press_down = 1'b0;
    logic                    i_ramp_tick = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_motor_speed;
    logic                    o_forward_led;
    logic                    o_reverse_led;
    logic [VAL_W-1:0]        o_target_now;
    logic [VAL_W-1:0]        o_position_now;

    // Predictor state, mirrors the block's registers.
    t_val  sp_full_scale = FULL_SCALE_RST;
    t_step sp_step       = RAMP_STEP_RST;
    t_val  sp_target     = TARGET_RST;
    t_val  sp_position   = POSITION_RST;

    t_drive_result pending_drive_q[$];
    int fail_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    motor_setpoint_slew_ramp_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_press_up     (i_press_up),
        .i_press_mirror (i_press_mirror),
        .i_press_down   (i_press_down),
        .i_ramp_tick    (i_ramp_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_motor_speed  (o_motor_speed),
        .o_forward_led  (o_forward_led),
        .o_reverse_led  (o_reverse_led),
        .o_target_now   (o_target_now),
        .o_position_now (o_position_now)
    );

    always #10 i_clk = ~i_clk;

    // Advance the predictor by one request and return the drive result it yields.
    function automatic t_drive_result predict_drive(input t_btn btn, input logic tick);
        t_drive_result res;
        int fs;
        int mid;
        int st;
        int t;
        int p;
        int spd;
        fs  = int'(sp_full_scale);
        mid = fs / 2;
        st  = int'(sp_step);
        t   = int'(sp_target);
        p   = int'(sp_position);
        if (btn.up) begin
            t = (t + 32 <= fs) ? t + 32 : fs;
        end
        if (btn.mirror) begin
            t = 2 * mid - t;
            if (t < 0) begin
                t = 0;
            end
        end
        if (btn.down) begin
            t = (t - 32 >= 0) ? t - 32 : 0;
        end
        if (tick) begin
            // snap zones first, then a single step toward the target
            if (t < st && p < st) begin
                p = 0;
            end else if (t > fs - st && p > fs - st) begin
                p = fs;
            end else if (t > p && t - p >= st) begin
                p = p + st;
            end else if (t < p && p - t >= st) begin
                p = p - st;
            end
        end
        sp_target   = t_val'(t);
        sp_position = t_val'(p);
        spd = mid - int'(sp_position);
        if (spd > 1023) begin
            spd = 1023;
        end
        if (spd < -1024) begin
            spd = -1024;
        end
        res.speed    = spd[VAL_W-1:0];
        res.fwd      = (spd > 0);
        res.rev      = (spd < 0);
        res.target   = sp_target;
        res.position = sp_position;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_val data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_FULL_SCALE) begin
            sp_full_scale = data;
        end else if (idx == CFG_RAMP_STEP) begin
            sp_step = data[STEP_W-1:0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input t_btn btn, input logic tick);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_press_up     <= btn.up;
        i_press_mirror <= btn.mirror;
        i_press_down   <= btn.down;
        i_ramp_tick    <= tick;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_drive_q.push_back(predict_drive(btn, tick));
    endtask

    // Drop valid and wait until every expected result is out.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_power_up();
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b0}, 1'b0);
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b0}, 1'b1);
        send_request('{up: 1'b1, mirror: 1'b0, down: 1'b0}, 1'b1);
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b1}, 1'b0);
        send_request('{up: 1'b1, mirror: 1'b1, down: 1'b1}, 1'b1);
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b1}, 1'b1);
        settle_block();
    endtask

    // Widest range and largest step, snap with zero step, speed saturation, clamps.
    task automatic test_range_extremes();
        write_reg(CFG_SPARE_A, t_val'(2047));
        write_reg(CFG_SPARE_B, t_val'(0));
        write_reg(CFG_FULL_SCALE, t_val'(2047));
        write_reg(CFG_RAMP_STEP, t_val'(2047));
        send_request('{up: 1'b0, mirror: 1'b1, down: 1'b0}, 1'b1);
        repeat (6) send_request('{up: 1'b0, mirror: 1'b0, down: 1'b0}, 1'b1);
        settle_block();
        write_reg(CFG_FULL_SCALE, t_val'(1500));
        write_reg(CFG_RAMP_STEP, t_val'(0));
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b0}, 1'b1);
        settle_block();
        write_reg(CFG_FULL_SCALE, t_val'(2));
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b0}, 1'b0);
        send_request('{up: 1'b1, mirror: 1'b0, down: 1'b0}, 1'b1);
        send_request('{up: 1'b0, mirror: 1'b1, down: 1'b0}, 1'b0);
        send_request('{up: 1'b1, mirror: 1'b1, down: 1'b1}, 1'b1);
        send_request('{up: 1'b0, mirror: 1'b0, down: 1'b1}, 1'b1);
        settle_block();
        write_reg(CFG_FULL_SCALE, t_val'(0));
        write_reg(CFG_RAMP_STEP, t_val'(128));
        send_request('{up: 1'b1, mirror: 1'b0, down: 1'b0}, 1'b1);
        send_request('{up: 1'b0, mirror: 1'b1, down: 1'b0}, 1'b1);
        settle_block();
    endtask

    task automatic apply_random_setting();
        t_val  fs;
        t_step st;
        case ($urandom_range(11))
            0:       fs = t_val'(0);
            1:       fs = t_val'(1);
            2:       fs = t_val'(2);
            3:       fs = t_val'(2047);
            4:       fs = t_val'(1024);
            5:       fs = t_val'($urandom);
            default: fs = t_val'($urandom_range(2, 1024));
        endcase
        case ($urandom_range(9))
            0:       st = t_step'(0);
            1:       st = t_step'(255);
            2:       st = t_step'(1);
            3:       st = t_step'(128);
            default: st = t_step'($urandom_range(1, 128));
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, t_val'($urandom));
        end
        write_reg(CFG_FULL_SCALE, fs);
        // upper data bits are outside the step register and must be ignored
        write_reg(CFG_RAMP_STEP, {3'($urandom), st});
    endtask

    task automatic run_random_burst(input int count);
        int   up_pct;
        int   mirror_pct;
        int   down_pct;
        int   tick_pct;
        t_btn btn;
        logic tick;
        up_pct     = $urandom_range(70);
        down_pct   = $urandom_range(70);
        mirror_pct = $urandom_range(25);
        tick_pct   = $urandom_range(20, 95);
        repeat (count) begin
            btn.up     = ($urandom_range(99) < up_pct);
            btn.mirror = ($urandom_range(99) < mirror_pct);
            btn.down   = ($urandom_range(99) < down_pct);
            tick       = ($urandom_range(99) < tick_pct);
            send_request(btn, tick);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int total);
        int sent;
        int burst;
        sent          = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (sent < total) begin
            settle_block();
            apply_random_setting();
            burst = $urandom_range(40, 160);
            // trim the last burst to the requested total
            if (burst > total - sent) begin
                burst = total - sent;
            end
            run_random_burst(burst);
            sent += burst;
        end
    endtask

    // Check results, drive the result-side ready and track handshake activity.
    always @(posedge i_clk) begin
        t_drive_result exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_drive_q.size() == 0) begin
                $display("%0t: unexpected result: speed %0d target %0d position %0d",
                         $time, o_motor_speed, o_target_now, o_position_now);
                fail_count++;
            end else begin
                exp = pending_drive_q.pop_front();
                if (o_motor_speed !== exp.speed) begin
                    $display("%0t: motor_speed expected %0d, actual %0d",
                             $time, exp.speed, o_motor_speed);
                    fail_count++;
                end
                if (o_forward_led !== exp.fwd) begin
                    $display("%0t: forward_led expected %0b, actual %0b",
                             $time, exp.fwd, o_forward_led);
                    fail_count++;
                end
                if (o_reverse_led !== exp.rev) begin
                    $display("%0t: reverse_led expected %0b, actual %0b",
                             $time, exp.rev, o_reverse_led);
                    fail_count++;
                end
                if (o_target_now !== exp.target) begin
                    $display("%0t: target_now expected %0d, actual %0d",
                             $time, exp.target, o_target_now);
                    fail_count++;
                end
                if (o_position_now !== exp.position) begin
                    $display("%0t: position_now expected %0d, actual %0d",
                             $time, exp.position, o_position_now);
                    fail_count++;
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_up();
        test_range_extremes();
        test_random_traffic(10, 88, 584);
        test_random_traffic(88, 10, 584);
        test_random_traffic(0, 0, 584);
        settle_block();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_drive_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/msr_pkg.sv
hdl/msr_target.sv
hdl/msr_ramp.sv
hdl/msr_speed.sv
hdl/motor_setpoint_slew_ramp_unit.sv
test/motor_setpoint_slew_ramp_unit_tb.sv
